@@ hdl/shrrip_pkg.sv @@
// Shared types, constants and codes of the SHiP/RRIP replacement core.
package shrrip_pkg;

    localparam int ADDR_W   = 64;
    localparam int SET_IN_W = 11;
    localparam int WAY_IN_W = 4;
    localparam int RRPV_W   = 2;
    localparam int CNTR_W   = 2;
    localparam int SCORE_W  = 3;
    localparam int THR_W    = 2;
    localparam int SEL_W    = 10;
    localparam int CFG_W    = 10;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_NUM_SETS    = 2048;
    localparam int DEF_NUM_WAYS    = 16;
    localparam int DEF_SIG_ENTRIES = 64;
    localparam int DEF_LEADER_SETS = 64;
    localparam int DEF_DELTA_DEPTH = 4;

    localparam logic [RRPV_W-1:0]  RRPV_MAX      = 2'd3;
    localparam logic [RRPV_W-1:0]  SRRIP_INSERT  = 2'd2;
    localparam logic [RRPV_W-1:0]  RRPV_HIT      = 2'd0;
    localparam logic [CNTR_W-1:0]  COUNTER_MAX   = 2'd3;
    localparam logic [CNTR_W-1:0]  COUNTER_REUSE = 2'd2;
    localparam logic [SCORE_W-1:0] SCORE_MAX     = 3'd7;
    localparam logic [SEL_W-1:0]   SELECTOR_MID  = 10'd511;

    localparam logic [THR_W-1:0]   THR_RESET   = 2'd3;
    localparam logic [SCORE_W-1:0] LEVEL_RESET = 3'd3;
    localparam logic [SEL_W-1:0]   SEL_RESET   = 10'd511;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_LVL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUEL_SEL   = 2'd2;

    typedef struct packed {
        logic                func;
        logic [SET_IN_W-1:0] set_index;
        logic [WAY_IN_W-1:0] way_index;
        logic [ADDR_W-1:0]   phys_addr;
        logic [ADDR_W-1:0]   prog_counter;
        logic [ADDR_W-1:0]   evicted_addr;
        logic                was_hit;
    } shrrip_in_t;

    typedef struct packed {
        logic [WAY_IN_W-1:0] victim_way;
        logic                streaming_seen;
        logic [RRPV_W-1:0]   inserted_rrpv;
    } shrrip_out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_AGE,
        ST_DELTA,
        ST_CMP,
        ST_WRITE,
        ST_READ_EV,
        ST_DECAY,
        ST_DONE
    } shrrip_state_t;

    typedef struct packed {
        logic start;
        logic update;
        logic hit;
        logic last;
    } shrrip_stat_t;

    typedef struct packed {
        shrrip_state_t state;
        logic          busy;
        logic          done;
    } shrrip_ctrl_t;

endpackage

@@ hdl/shrrip_alu.sv @@
// Shared 64-bit subtractor: deltas, delta compares and RRPV compares.
module shrrip_alu (
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] diff,
    output logic        borrow,
    output logic        equal
);
    logic [64:0] full;

    assign full   = {1'b0, a} - {1'b0, b};
    assign diff   = full[63:0];
    assign borrow = full[64];
    assign equal  = (full[63:0] == 64'd0);
endmodule

@@ hdl/shrrip_fsm.sv @@
// Sequencer of the replacement core: clear pass, find and update flows.
module shrrip_fsm (
    input  logic                     clk,
    input  logic                     rst_n,
    input  shrrip_pkg::shrrip_stat_t stat,
    output shrrip_pkg::shrrip_ctrl_t ctrl
);
    import shrrip_pkg::*;

    shrrip_state_t state_reg;
    shrrip_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:   if (stat.last) state_next = ST_IDLE;
            ST_IDLE:    if (stat.start) state_next = ST_READ;
            ST_READ:    state_next = stat.update ? ST_DELTA : ST_SCAN;
            ST_SCAN:    if (stat.last) state_next = ST_AGE;
            ST_AGE:     state_next = ST_DONE;
            ST_DELTA:   state_next = ST_CMP;
            ST_CMP:     if (stat.last) state_next = ST_WRITE;
            ST_WRITE:   state_next = stat.hit ? ST_DONE : ST_READ_EV;
            ST_READ_EV: state_next = ST_DECAY;
            ST_DECAY:   state_next = ST_DONE;
            ST_DONE:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.state = state_reg;
        ctrl.busy  = (state_reg != ST_IDLE);
        ctrl.done  = (state_reg == ST_DONE);
    end
endmodule

@@ hdl/ship_rrip_replacement_with_stream_detect_core.sv @@
// Top level of the SHiP/RRIP replacement core with per-set stream detector.
// Usage: after reset the core sweeps its tables (RRPV rows to 3, detector
// entries and reuse counters to 0) with busy high; configuration writes are
// taken at any time the core is idle. NUM_SETS, NUM_WAYS, SIG_ENTRIES and
// DELTA_DEPTH must be powers of two; the core does not enforce this. The set,
// the way and both signatures are reduced by masking when the command transfers.
// A command transfers when start is high and busy is low. The core then runs
// one command at a time on a single shared 64-bit subtractor. A find reads the
// set's row, compares one way per cycle across all NUM_WAYS ways and then ages
// the row, after which done rises. An update reads the set, forms the delta,
// compares ring slots 1..DELTA_DEPTH-1 one per cycle and writes back; a fill
// also reads and decays the evicted signature's counter before done. The
// result is shown for exactly one cycle with done high; the receiver cannot
// stall it, so take it in that cycle. busy falls the cycle after done, and no
// new command is taken before then.
module ship_rrip_replacement_with_stream_detect_core #(
    parameter int NUM_SETS    = shrrip_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS    = shrrip_pkg::DEF_NUM_WAYS,
    parameter int SIG_ENTRIES = shrrip_pkg::DEF_SIG_ENTRIES,
    parameter int LEADER_SETS = shrrip_pkg::DEF_LEADER_SETS,
    parameter int DELTA_DEPTH = shrrip_pkg::DEF_DELTA_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  shrrip_pkg::shrrip_in_t               cmd,
    output logic                                 done,
    output shrrip_pkg::shrrip_out_t              result,
    input  logic                                 cfg_we,
    input  logic [shrrip_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [shrrip_pkg::CFG_W-1:0]         cfg_data
);
    import shrrip_pkg::*;

    localparam int SET_W     = $clog2(NUM_SETS);
    localparam int WAY_W     = $clog2(NUM_WAYS);
    localparam int SIG_W     = $clog2(SIG_ENTRIES);
    localparam int PTR_W     = $clog2(DELTA_DEPTH);
    localparam int CLR_DEPTH = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
    localparam int CNT_W     = $clog2(CLR_DEPTH + 1);
    localparam int SET_KEEP  = (SET_W < SET_IN_W) ? SET_W : SET_IN_W;
    localparam int WAY_KEEP  = (WAY_W < WAY_IN_W) ? WAY_W : WAY_IN_W;

    typedef logic [NUM_WAYS-1:0][RRPV_W-1:0] row_t;
    typedef logic [DELTA_DEPTH-1:0][ADDR_W-1:0] ring_t;

    shrrip_ctrl_t ctrl;
    shrrip_stat_t stat;
    shrrip_state_t st;

    // configuration
    logic [THR_W-1:0]   thr_reg;
    logic [SCORE_W-1:0] level_reg;
    logic [SEL_W-1:0]   sel_reg;

    // command context
    shrrip_in_t        cmd_reg;
    logic [SET_W-1:0]  set_reg, set_next;
    logic [WAY_W-1:0]  way_reg, way_next;
    logic [SIG_W-1:0]  sigpc_reg, sigpc_next;
    logic [SIG_W-1:0]  sigev_reg, sigev_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic [RRPV_W-1:0] top_reg, top_next;
    logic [WAY_W-1:0]  pick_reg, pick_next;
    ring_t             ring_reg, ring_next;
    logic [PTR_W-1:0]  same_reg, same_next;
    shrrip_out_t       res_reg, res_next;

    // memories and their registered read data
    row_t               rrpv_mem [NUM_SETS];
    logic [ADDR_W-1:0]  last_mem [NUM_SETS];
    ring_t              ring_mem [NUM_SETS];
    logic [PTR_W-1:0]   ptr_mem [NUM_SETS];
    logic [SCORE_W-1:0] score_mem [NUM_SETS];
    logic [CNTR_W-1:0]  reuse_mem [SIG_ENTRIES];

    row_t               rrpv_rd;
    logic [ADDR_W-1:0]  last_rd;
    ring_t              ring_rd;
    logic [PTR_W-1:0]   ptr_rd;
    logic [SCORE_W-1:0] score_rd;
    logic [CNTR_W-1:0]  reuse_rd;

    logic               rrpv_we, det_we, reuse_we;
    logic [SET_W-1:0]   set_waddr;
    row_t               rrpv_wdata;
    logic [ADDR_W-1:0]  last_wdata;
    ring_t              ring_wdata;
    logic [PTR_W-1:0]   ptr_wdata;
    logic [SCORE_W-1:0] score_wdata;
    logic [SIG_W-1:0]   reuse_waddr, reuse_raddr;
    logic [CNTR_W-1:0]  reuse_wdata;

    // shared unit
    logic [63:0] alu_a, alu_b, alu_diff;
    logic        alu_borrow, alu_equal;

    logic               clr_in_sets, clr_in_sigs;
    logic [SCORE_W-1:0] score_new;
    logic               streaming;
    logic [RRPV_W-1:0]  fill_rrpv;
    logic [RRPV_W-1:0]  lift;
    row_t               aged_row, upd_row;
    logic [PTR_W-1:0]   ptr_inc;
    logic [63:0]        hash_pc, hash_ev;

    shrrip_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    shrrip_alu u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .diff   (alu_diff),
        .borrow (alu_borrow),
        .equal  (alu_equal)
    );

    assign st     = ctrl.state;
    assign busy   = ctrl.busy;
    assign done   = ctrl.done;
    assign result = res_reg;

    // signatures of the incoming command; only the low bits survive the mask
    assign hash_pc = cmd.prog_counter ^ (cmd.prog_counter >> 2);
    assign hash_ev = cmd.evicted_addr ^ (cmd.evicted_addr >> 2);

    assign clr_in_sets = (32'(step_reg) < NUM_SETS);
    assign clr_in_sigs = (32'(step_reg) < SIG_ENTRIES);

    // phase ends
    always_comb
    begin
        stat.start  = start;
        stat.update = cmd_reg.func;
        stat.hit    = cmd_reg.was_hit;
        unique case (st)
            ST_CLEAR:   stat.last = (step_reg == CNT_W'(CLR_DEPTH - 1));
            ST_SCAN:    stat.last = (step_reg == CNT_W'(NUM_WAYS - 1));
            ST_CMP:     stat.last = (step_reg == CNT_W'(DELTA_DEPTH - 1));
            default:    stat.last = 1'b0;
        endcase
    end

    // operand select for the shared subtractor
    always_comb
    begin
        alu_a = 64'd0;
        alu_b = 64'd0;
        unique case (st)
            ST_SCAN:
            begin
                alu_a = 64'(top_reg);
                alu_b = 64'(rrpv_rd[step_reg[WAY_W-1:0]]);
            end
            ST_DELTA:
            begin
                alu_a = cmd_reg.phys_addr;
                alu_b = last_rd;
            end
            ST_CMP:
            begin
                alu_a = ring_reg[step_reg[PTR_W-1:0]];
                alu_b = ring_reg[0];
            end
            default:
            begin
                alu_a = 64'd0;
                alu_b = 64'd0;
            end
        endcase
    end

    // stream verdict and insertion choice
    always_comb
    begin
        if ({2'b00, same_reg} >= 4'(thr_reg))
        begin
            score_new = (score_rd == SCORE_MAX) ? score_rd : score_rd + 1'b1;
        end
        else
        begin
            score_new = (score_rd == '0) ? score_rd : score_rd - 1'b1;
        end
        streaming = (score_new >= level_reg);
        priority if (streaming)
            fill_rrpv = RRPV_MAX;
        else if (reuse_rd >= COUNTER_REUSE)
            fill_rrpv = RRPV_HIT;
        else if (32'(set_reg) < LEADER_SETS)
            fill_rrpv = SRRIP_INSERT;
        else if (32'(set_reg) >= NUM_SETS - LEADER_SETS)
            fill_rrpv = RRPV_MAX;
        else
            fill_rrpv = (sel_reg >= SELECTOR_MID) ? SRRIP_INSERT : RRPV_MAX;
    end

    assign lift    = RRPV_MAX - top_reg;
    assign ptr_inc = (ptr_rd == PTR_W'(DELTA_DEPTH - 1)) ? '0 : ptr_rd + 1'b1;

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            aged_row[w] = rrpv_rd[w] + lift;
        end
        upd_row = rrpv_rd;
        upd_row[way_reg] = cmd_reg.was_hit ? RRPV_HIT : fill_rrpv;
    end

    // datapath next values
    always_comb
    begin
        set_next   = set_reg;
        way_next   = way_reg;
        sigpc_next = sigpc_reg;
        sigev_next = sigev_reg;
        step_next  = '0;
        top_next   = top_reg;
        pick_next  = pick_reg;
        ring_next  = ring_reg;
        same_next  = same_reg;
        res_next   = res_reg;
        unique case (st)
            ST_CLEAR:
            begin
                step_next = stat.last ? '0 : step_reg + 1'b1;
            end
            ST_IDLE:
            begin
                // reduce set, way and signatures by masking as the command transfers
                if (start)
                begin
                    set_next   = SET_W'(cmd.set_index[SET_KEEP-1:0]);
                    way_next   = WAY_W'(cmd.way_index[WAY_KEEP-1:0]);
                    sigpc_next = hash_pc[SIG_W-1:0];
                    sigev_next = hash_ev[SIG_W-1:0];
                end
            end
            ST_READ:
            begin
                top_next  = '0;
                pick_next = '0;
                same_next = '0;
            end
            ST_SCAN:
            begin
                step_next = stat.last ? '0 : step_reg + 1'b1;
                if (alu_borrow)
                begin
                    top_next  = rrpv_rd[step_reg[WAY_W-1:0]];
                    pick_next = step_reg[WAY_W-1:0];
                end
            end
            ST_AGE:
            begin
                res_next.victim_way     = WAY_IN_W'(pick_reg);
                res_next.streaming_seen = 1'b0;
                res_next.inserted_rrpv  = RRPV_HIT;
            end
            ST_DELTA:
            begin
                ring_next = ring_rd;
                ring_next[ptr_rd] = alu_diff;
                step_next = CNT_W'(1);
            end
            ST_CMP:
            begin
                step_next = stat.last ? '0 : step_reg + 1'b1;
                same_next = same_reg + PTR_W'(alu_equal);
            end
            ST_WRITE:
            begin
                res_next.victim_way     = '0;
                res_next.streaming_seen = streaming;
                res_next.inserted_rrpv  = cmd_reg.was_hit ? RRPV_HIT : fill_rrpv;
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    // memory write ports
    always_comb
    begin
        rrpv_we     = 1'b0;
        det_we      = 1'b0;
        reuse_we    = 1'b0;
        set_waddr   = set_reg;
        rrpv_wdata  = upd_row;
        last_wdata  = cmd_reg.phys_addr;
        ring_wdata  = ring_reg;
        ptr_wdata   = ptr_inc;
        score_wdata = score_new;
        reuse_waddr = sigpc_reg;
        reuse_wdata = (reuse_rd == COUNTER_MAX) ? reuse_rd : reuse_rd + 1'b1;
        unique case (st)
            ST_CLEAR:
            begin
                rrpv_we     = clr_in_sets;
                det_we      = clr_in_sets;
                reuse_we    = clr_in_sigs;
                set_waddr   = step_reg[SET_W-1:0];
                rrpv_wdata  = {NUM_WAYS{RRPV_MAX}};
                last_wdata  = '0;
                ring_wdata  = '0;
                ptr_wdata   = '0;
                score_wdata = '0;
                reuse_waddr = step_reg[SIG_W-1:0];
                reuse_wdata = '0;
            end
            ST_AGE:
            begin
                rrpv_we    = 1'b1;
                rrpv_wdata = aged_row;
            end
            ST_WRITE:
            begin
                rrpv_we  = 1'b1;
                det_we   = 1'b1;
                reuse_we = cmd_reg.was_hit;
            end
            ST_DECAY:
            begin
                reuse_we    = 1'b1;
                reuse_waddr = sigev_reg;
                reuse_wdata = (reuse_rd == '0) ? reuse_rd : reuse_rd - 1'b1;
            end
            default:
            begin
                rrpv_we = 1'b0;
            end
        endcase
    end

    assign reuse_raddr = (st == ST_READ_EV) ? sigev_reg : sigpc_reg;

    always_ff @(posedge clk)
    begin
        if (rrpv_we)
        begin
            rrpv_mem[set_waddr] <= rrpv_wdata;
        end
        if (det_we)
        begin
            last_mem[set_waddr]  <= last_wdata;
            ring_mem[set_waddr]  <= ring_wdata;
            ptr_mem[set_waddr]   <= ptr_wdata;
            score_mem[set_waddr] <= score_wdata;
        end
        if (reuse_we)
        begin
            reuse_mem[reuse_waddr] <= reuse_wdata;
        end
        if (st == ST_READ)
        begin
            rrpv_rd  <= rrpv_mem[set_reg];
            last_rd  <= last_mem[set_reg];
            ring_rd  <= ring_mem[set_reg];
            ptr_rd   <= ptr_mem[set_reg];
            score_rd <= score_mem[set_reg];
        end
        if (st == ST_READ || st == ST_READ_EV)
        begin
            reuse_rd <= reuse_mem[reuse_raddr];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (st == ST_IDLE && start)
        begin
            cmd_reg <= cmd;
        end
        set_reg   <= set_next;
        way_reg   <= way_next;
        sigpc_reg <= sigpc_next;
        sigev_reg <= sigev_next;
        top_reg   <= top_next;
        pick_reg  <= pick_next;
        ring_reg  <= ring_next;
        same_reg  <= same_next;
        res_reg   <= res_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            thr_reg   <= THR_RESET;
            level_reg <= LEVEL_RESET;
            sel_reg   <= SEL_RESET;
        end
        else
        begin
            step_reg <= step_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MATCH_THR:  thr_reg   <= cfg_data[THR_W-1:0];
                    CFG_STREAM_LVL: level_reg <= cfg_data[SCORE_W-1:0];
                    CFG_DUEL_SEL:   sel_reg   <= cfg_data[SEL_W-1:0];
                    default:        thr_reg   <= thr_reg;
                endcase
            end
        end
    end

    // a transferred command keeps the core busy in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("command accepted but core not busy");

    // the result strobe lasts exactly one cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held longer than one cycle");

    // a find reports no stream verdict and no insertion
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !cmd_reg.func) |-> (!result.streaming_seen && result.inserted_rrpv == RRPV_HIT))
        else $error("find result carries update fields");

    // an update never names a victim, and a hit always promotes to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && cmd_reg.func) |->
            (result.victim_way == '0 && (!cmd_reg.was_hit || result.inserted_rrpv == RRPV_HIT)))
        else $error("update result inconsistent");

    // aging always lands the chosen victim at the distant value
    assert property (@(posedge clk) disable iff (!rst_n)
        (st == ST_AGE) |-> (aged_row[pick_reg] == RRPV_MAX))
        else $error("aged victim not at maximum RRPV");
endmodule
